// ----- rtl/hbd_pkg.sv -----
`timescale 1ns / 1ps

package hbd_pkg;

	// Octet counter width and saturation value
	localparam int COUNT_WIDTH = 10;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Width used when comparing the counter against a 10-bit register
	localparam int CMP_W = (COUNT_WIDTH > 10) ? COUNT_WIDTH : 10;

	// Descrambler polynomial x^17 + x^12 + 1
	localparam int SCR_LEN  = 17;
	localparam int SCR_TAP0 = 16;
	localparam int SCR_TAP1 = 11;

	// Pattern detector codes
	localparam logic [7:0] FLAG_PATTERN  = 8'h7E;
	localparam logic [7:0] ABORT_PATTERN = 8'hFE;
	localparam logic [7:0] STUFF_MASK    = 8'hFC;
	localparam logic [7:0] STUFF_PATTERN = 8'h7C;

	// Bit counter code for "not collecting"
	localparam logic [3:0] BITS_IDLE = 4'd15;
	localparam logic [3:0] BITS_LAST = 4'd7;

	typedef enum logic [1:0] {
		EV_OCTET = 2'd0,
		EV_FLAG  = 2'd1,
		EV_ABORT = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		CFG_SCRAMBLE  = 2'd0,
		CFG_MIN_OCTET = 2'd1,
		CFG_MAX_OCTET = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic                   valid;
		event_t                 ev;
		logic [7:0]             octet;
		logic [COUNT_WIDTH-1:0] count;
	} res_t;

endpackage

// ----- rtl/hdlc_bit_deframer_unit.sv -----
`timescale 1ns / 1ps

// HDLC receive deframer, one line bit per request.
// Input channel (in_valid/in_ready, raw_bit): one demodulated line bit per
// request. The bit is optionally descrambled (x^17+x^12+1), NRZI decoded,
// and run through the flag/abort/stuffing detector and octet assembler.
// Output channel (out_valid/out_ready): zero or one result per input bit:
// event_res 0 with a completed octet and the running count, 1 when a
// closing flag ends a long enough frame, 2 when seven ones abort a frame.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no request is in flight.
// A bit accepted lands in the input register, is decoded into the output
// register once the result slot is free and then shows on the output ports.
// Throughput: one bit per cycle while results are taken, set by the single
// decode step between the input register and the output register.
// When the receiver stalls, the held result blocks the decode step, the
// input register fills and in_ready drops; nothing is lost.
// Reset: all decoder state clears, collection starts idle (hunting for a
// flag), registers return to scramble off, min 17 and max 332 octets.
module hdlc_bit_deframer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       raw_bit,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_res,
	output logic [7:0] octet,
	output logic [9:0] frame_octets,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	// Configuration registers
	logic       scramble_q;
	logic [9:0] min_q;
	logic [9:0] max_q;

	// Input register stage
	logic valid_s1;
	logic raw_s1;

	// Output register
	logic                            out_valid_q;
	hbd_pkg::event_t                 event_q;
	logic [7:0]                      octet_q;
	logic [hbd_pkg::COUNT_WIDTH-1:0] count_q;

	logic          out_free;
	logic          advance;
	logic          dbit;
	hbd_pkg::res_t res;

	assign cfg_ready = 1'b1;

	// Decode one bit when the input register holds one and the result slot
	// is empty or being emptied this cycle.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scramble_q <= 1'b0;
			min_q      <= 10'd17;
			max_q      <= 10'd332;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hbd_pkg::CFG_SCRAMBLE:  scramble_q <= cfg_data[0];
				hbd_pkg::CFG_MIN_OCTET: min_q      <= cfg_data;
				hbd_pkg::CFG_MAX_OCTET: max_q      <= cfg_data;
				default: ; // ignore writes to unknown indexes
			endcase
		end
	end

	// Hold the input bit until the decoder takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_bit;
		end
	end

	hbd_line_decoder u_line (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.raw_bit         (raw_s1),
		.scramble_enable (scramble_q),
		.dbit            (dbit)
	);

	hbd_frame_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.dbit             (dbit),
		.min_frame_octets (min_q),
		.max_frame_octets (max_q),
		.res              (res)
	);

	// Result slot: load on a decode that yields a result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			event_q <= res.ev;
			octet_q <= res.octet;
			count_q <= res.count;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = event_q;
	assign octet        = octet_q;
	assign frame_octets = 10'(count_q);

endmodule

// ----- rtl/hbd_line_decoder.sv -----
`timescale 1ns / 1ps

module hbd_line_decoder (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic raw_bit,
	input  logic scramble_enable,
	output logic dbit
);

	logic [hbd_pkg::SCR_LEN-1:0] scr_q;
	logic                        last_line_q;
	logic                        last_desc_q;
	logic                        desc_bit;

	assign desc_bit = raw_bit ^ scr_q[hbd_pkg::SCR_TAP0] ^ scr_q[hbd_pkg::SCR_TAP1];

	// NRZI: a one is an unchanged level
	always_comb begin
		if (scramble_enable) begin
			dbit = (desc_bit == last_desc_q);
		end else begin
			dbit = (raw_bit == last_line_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_q       <= '0;
			last_line_q <= 1'b0;
			last_desc_q <= 1'b0;
		end else if (advance) begin
			last_line_q <= raw_bit;
			if (scramble_enable) begin
				scr_q       <= {scr_q[hbd_pkg::SCR_LEN-2:0], raw_bit};
				last_desc_q <= desc_bit;
			end
		end
	end

endmodule

// ----- rtl/hbd_frame_core.sv -----
`timescale 1ns / 1ps

module hbd_frame_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic                            dbit,
	input  logic [9:0]                      min_frame_octets,
	input  logic [9:0]                      max_frame_octets,
	output hbd_pkg::res_t                   res
);

	logic [7:0]                      pat_q;
	logic [7:0]                      oct_q;
	logic [3:0]                      bits_q;
	logic [hbd_pkg::COUNT_WIDTH-1:0] count_q;

	logic [7:0]                      pat_n;
	logic [7:0]                      oct_n;
	logic [3:0]                      bits_n;
	logic [3:0]                      bits_inc;
	logic [hbd_pkg::COUNT_WIDTH-1:0] count_n;
	logic                            below_max;
	logic                            at_min;

	assign pat_n    = {dbit, pat_q[7:1]};
	assign bits_inc = bits_q + 4'd1;
	assign below_max = (hbd_pkg::CMP_W'(count_q) < hbd_pkg::CMP_W'(max_frame_octets))
		&& (count_q != hbd_pkg::COUNT_MAX);
	assign at_min = (hbd_pkg::CMP_W'(count_q) >= hbd_pkg::CMP_W'(min_frame_octets));

	always_comb begin
		oct_n     = oct_q;
		bits_n    = bits_q;
		count_n   = count_q;
		res.valid = 1'b0;
		res.ev    = hbd_pkg::EV_OCTET;
		res.octet = 8'd0;
		res.count = count_q;
		if (pat_n == hbd_pkg::FLAG_PATTERN) begin
			bits_n  = 4'd0;
			count_n = '0;
			res.ev  = hbd_pkg::EV_FLAG;
			res.valid = (bits_q == hbd_pkg::BITS_LAST) && at_min;
		end else if (pat_n == hbd_pkg::ABORT_PATTERN) begin
			bits_n  = hbd_pkg::BITS_IDLE;
			count_n = '0;
			res.ev  = hbd_pkg::EV_ABORT;
			res.valid = (bits_q != hbd_pkg::BITS_IDLE);
		end else if ((pat_n & hbd_pkg::STUFF_MASK) == hbd_pkg::STUFF_PATTERN) begin
			// drop stuffed zero
		end else if (bits_q != hbd_pkg::BITS_IDLE) begin
			oct_n = {dbit, oct_q[7:1]};
			if (bits_q == hbd_pkg::BITS_LAST) begin
				bits_n = 4'd0;
				if (below_max) begin
					count_n   = count_q + 1'b1;
					res.valid = 1'b1;
					res.octet = oct_n;
					res.count = count_n;
				end
			end else begin
				bits_n = bits_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q   <= 8'd0;
			oct_q   <= 8'd0;
			bits_q  <= hbd_pkg::BITS_IDLE;
			count_q <= '0;
		end else if (advance) begin
			pat_q   <= pat_n;
			oct_q   <= oct_n;
			bits_q  <= bits_n;
			count_q <= count_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(bits_q == hbd_pkg::BITS_IDLE) |-> (count_q == '0))
		else $error("octet count nonzero while idle");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bits_q <= hbd_pkg::BITS_LAST) || (bits_q == hbd_pkg::BITS_IDLE))
		else $error("bit counter out of range");

	a_octet_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.valid && (res.ev == hbd_pkg::EV_OCTET))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("emitted octet did not advance the count");
`endif

endmodule

// ----- sim/hdlc_bit_deframer_checker.sv -----
`timescale 1ns / 1ps

module hdlc_bit_deframer_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       raw_bit,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] event_res,
	input  logic [7:0] octet,
	input  logic [9:0] frame_octets,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	output int         mismatches,
	output int         outstanding
);

	typedef struct {
		hbd_pkg::event_t ev;
		logic [7:0]      oct;
		logic [9:0]      total;
	} frame_event_t;

	frame_event_t frame_events[$];

	// register copies
	logic       scr_en;
	logic [9:0] min_oct;
	logic [9:0] max_oct;

	// receiver state
	logic                            line_prev;
	logic [hbd_pkg::SCR_LEN-1:0]     scr_reg;
	logic                            desc_prev;
	logic [7:0]                      pat;
	logic [7:0]                      oct_sr;
	logic [3:0]                      nbits;
	logic [hbd_pkg::COUNT_WIDTH-1:0] cnt;

	function automatic void decode_line_bit(input logic rb, output bit hit,
			output frame_event_t r);
		logic                      ds;
		logic                      dbit;
		logic [hbd_pkg::CMP_W-1:0] cap;
		hit = 1'b0;
		r.ev = hbd_pkg::EV_OCTET;
		r.oct = 8'h00;
		r.total = '0;
		if (scr_en) begin
			ds = rb ^ scr_reg[hbd_pkg::SCR_TAP0] ^ scr_reg[hbd_pkg::SCR_TAP1];
			scr_reg = {scr_reg[hbd_pkg::SCR_LEN-2:0], rb};
			dbit = (ds == desc_prev);
			desc_prev = ds;
		end else begin
			dbit = (rb == line_prev);
		end
		line_prev = rb;
		pat = {dbit, pat[7:1]};
		if (pat == hbd_pkg::FLAG_PATTERN) begin
			if (nbits == hbd_pkg::BITS_LAST && cnt >= min_oct) begin
				hit = 1'b1;
				r.ev = hbd_pkg::EV_FLAG;
				r.total = cnt;
			end
			nbits = 4'd0;
			cnt = '0;
		end else if (pat == hbd_pkg::ABORT_PATTERN) begin
			if (nbits != hbd_pkg::BITS_IDLE) begin
				hit = 1'b1;
				r.ev = hbd_pkg::EV_ABORT;
				r.total = cnt;
			end
			nbits = hbd_pkg::BITS_IDLE;
			cnt = '0;
		end else if ((pat & hbd_pkg::STUFF_MASK) != hbd_pkg::STUFF_PATTERN
				&& nbits != hbd_pkg::BITS_IDLE) begin
			oct_sr = {dbit, oct_sr[7:1]};
			if (nbits == hbd_pkg::BITS_LAST) begin
				nbits = 4'd0;
				cap = (max_oct < hbd_pkg::COUNT_MAX) ? max_oct : hbd_pkg::COUNT_MAX;
				if (cnt < cap) begin
					cnt = cnt + 1'b1;
					hit = 1'b1;
					r.oct = oct_sr;
					r.total = cnt;
				end
			end else begin
				nbits = nbits + 1'b1;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_event_t want;
		frame_event_t fresh;
		bit           hit;
		if (!arst_n) begin
			scr_en = 1'b0;
			min_oct = 10'd17;
			max_oct = 10'd332;
			line_prev = 1'b0;
			scr_reg = '0;
			desc_prev = 1'b0;
			pat = 8'h00;
			oct_sr = 8'h00;
			nbits = hbd_pkg::BITS_IDLE;
			cnt = '0;
			frame_events.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (frame_events.size() == 0) begin
					$error("unexpected result: event_res %0d octet %0d frame_octets %0d",
						event_res, octet, frame_octets);
					mismatches++;
				end else begin
					want = frame_events.pop_front();
					if (event_res !== want.ev) begin
						$error("event_res: expected %0d, actual %0d", want.ev, event_res);
						mismatches++;
					end
					if (octet !== want.oct) begin
						$error("octet: expected %0d, actual %0d", want.oct, octet);
						mismatches++;
					end
					if (frame_octets !== want.total) begin
						$error("frame_octets: expected %0d, actual %0d",
							want.total, frame_octets);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (hbd_pkg::cfg_index_t'(cfg_index))
					hbd_pkg::CFG_SCRAMBLE:  scr_en = cfg_data[0];
					hbd_pkg::CFG_MIN_OCTET: min_oct = cfg_data;
					hbd_pkg::CFG_MAX_OCTET: max_oct = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				decode_line_bit(raw_bit, hit, fresh);
				if (hit)
					frame_events.push_back(fresh);
			end
			outstanding = frame_events.size();
		end
	end

endmodule

// ----- sim/hdlc_bit_deframer_unit_test.sv -----
`timescale 1ns / 1ps

module hdlc_bit_deframer_unit_test;

	// Run limit in cycles: ~650 requests, each with its longest input gap and
	// receiver stall plus pipeline, taken many times over.
	localparam int LIMIT        = 200000;
	// Cycles to let in-flight requests that make no result pass the pipeline.
	localparam int DRAIN_CYCLES = 6;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic       raw_bit   = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] event_res;
	logic [7:0] octet;
	logic [9:0] frame_octets;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = hbd_pkg::CFG_SCRAMBLE;
	logic [9:0] cfg_data  = 10'd0;

	int mismatches;
	int outstanding;
	int cycles      = 0;
	int bits_sent   = 0;
	int stall_left  = 0;
	bit idle_on     = 1'b1;

	// Line encoder state: mirrors what the receiver must see so that
	// generated frames decode cleanly (NRZI, optional scrambler).
	logic                        enc_scr   = 1'b0;
	logic                        enc_line  = 1'b0;
	logic                        enc_level = 1'b0;
	logic [hbd_pkg::SCR_LEN-1:0] enc_shift = '0;
	int                          ones_run  = 0;

	always #4 clk = ~clk;

	hdlc_bit_deframer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.raw_bit      (raw_bit),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.octet        (octet),
		.frame_octets (frame_octets),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	hdlc_bit_deframer_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.raw_bit      (raw_bit),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.octet        (octet),
		.frame_octets (frame_octets),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Receiver back-pressure: stall in random bursts while idling
	// is allowed, otherwise always take the result.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: stop a run that hangs.
	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Present one line bit as a request and hold it until accepted. Called
	// at a falling edge and returns at one; valid stays high between
	// back-to-back requests, so it is never dropped and raised in one step.
	task automatic send_bit(input logic b);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		raw_bit  <= b;
		do @(posedge clk); while (!in_ready);
		bits_sent++;
		@(negedge clk);
	endtask

	// Encode one data bit onto the line: NRZI (1 = no transition), then
	// scramble when enabled.
	task automatic send_data(input logic d);
		logic rb;
		if (enc_scr) begin
			enc_level = d ? enc_level : ~enc_level;
			rb = enc_level ^ enc_shift[hbd_pkg::SCR_TAP0] ^ enc_shift[hbd_pkg::SCR_TAP1];
			enc_shift = {enc_shift[hbd_pkg::SCR_LEN-2:0], rb};
		end else begin
			rb = d ? enc_line : ~enc_line;
		end
		enc_line = rb;
		send_bit(rb);
	endtask

	task automatic send_flag();
		int i;
		for (i = 0; i < 8; i++)
			send_data(hbd_pkg::FLAG_PATTERN[i]);
		ones_run = 0;
	endtask

	// Send an octet LSB first; insert a zero after every five ones.
	task automatic send_octet(input logic [7:0] o);
		int i;
		for (i = 0; i < 8; i++) begin
			send_data(o[i]);
			if (o[i]) begin
				ones_run++;
				if (ones_run == 5) begin
					send_data(1'b0);
					ones_run = 0;
				end
			end else begin
				ones_run = 0;
			end
		end
	endtask

	task automatic send_ones(input int n);
		repeat (n) send_data(1'b1);
		ones_run = 0;
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_data(1'($urandom_range(0, 1)));
		ones_run = 0;
	endtask

	// Bias toward octets that exercise stuffing and flag look-alikes.
	function automatic logic [7:0] random_octet();
		case ($urandom_range(0, 7))
			0: return 8'hFF;
			1: return 8'h00;
			2: return hbd_pkg::FLAG_PATTERN;
			3: return 8'hF8;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Hold off new requests until every expected result has come, then let
	// the pipeline empty of bits that make no result.
	task automatic settle();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write all three registers back to back; only while the block is idle.
	task automatic apply_settings(input logic scr, input logic [9:0] mn,
			input logic [9:0] mx);
		hbd_pkg::cfg_index_t order[3];
		logic [9:0]          vals[3];
		int                  i;
		order[0] = hbd_pkg::CFG_SCRAMBLE;
		order[1] = hbd_pkg::CFG_MIN_OCTET;
		order[2] = hbd_pkg::CFG_MAX_OCTET;
		vals[0] = {9'd0, scr};
		vals[1] = mn;
		vals[2] = mx;
		for (i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		enc_scr = scr;
	endtask

	// One setting, then random frames until the bit budget is spent.
	// Mostly well-formed frames with random content; the rest are frames
	// with a ragged tail, aborted frames, line noise and marking idle.
	task automatic run_phase(input logic scr, input logic [9:0] mn,
			input logic [9:0] mx, input int budget);
		int stop_at;
		int n;
		int kind;
		settle();
		apply_settings(scr, mn, mx);
		stop_at = bits_sent + budget;
		while (bits_sent < stop_at) begin
			kind = $urandom_range(0, 9);
			n = (kind == 5) ? $urandom_range(0, 8) : $urandom_range(0, 4);
			case (kind)
				8: send_noise($urandom_range(1, 20));
				9: send_ones($urandom_range(8, 15));
				default: begin
					send_flag();
					repeat (n) send_octet(random_octet());
					if (kind == 6) begin
						// misaligned: closing flag with a partial octet pending
						send_noise($urandom_range(1, 7));
						send_flag();
					end else if (kind == 7) begin
						send_ones($urandom_range(7, 9));
					end else begin
						send_flag();
					end
				end
			endcase
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: opening flag, an all-ones octet that needs a stuffed
		// zero, closing flag that ends the frame, then seven ones to abort
		// the collection restarted by that flag.
		apply_settings(1'b0, 10'd1, 10'd1023);
		send_flag();
		send_octet(8'hFF);
		send_flag();
		send_ones(7);

		run_phase(1'b1, 10'd2,    10'd1023, 75);
		// largest minimum never lets a frame end; max 1 saturates at once
		run_phase(1'b0, 10'd1023, 10'd1,    75);
		run_phase(1'b1, 10'd1,    10'd3,    75);
		// zero registers: every octet dropped, any aligned flag ends a frame
		run_phase(1'b0, 10'd0,    10'd0,    75);
		run_phase(1'b1, 10'd4,    10'd332,  75);
		run_phase(1'b0, 10'($urandom_range(1, 6)), 10'($urandom_range(2, 8)), 75);
		// last stretch runs with no idling on either side
		settle();
		idle_on = 1'b0;
		run_phase(1'b1, 10'd3,    10'd5,    65);

		settle();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
